// File: hdl/pwr_pkg.sv
package pwr_pkg;

  // item function codes
  localparam logic [1:0] FUNC_XLATE  = 2'd0;
  localparam logic [1:0] FUNC_REWIRE = 2'd1;
  localparam logic [1:0] FUNC_DATA   = 2'd2;

  // entry bit positions
  localparam int unsigned PRESENT_BIT = 0;
  localparam int unsigned PS_BIT      = 7;

  // output queue
  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_DONE  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_MISMATCH = 2'd0,
    ST_SUCCESS  = 2'd1,
    ST_FAULT    = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_SRC_TOP  = 3'd1,
    PH_SRC_PDPT = 3'd2,
    PH_DST_TOP  = 3'd3,
    PH_DST_PDPT = 3'd4,
    PH_RECHECK  = 3'd5
  } phase_e;

  typedef struct packed {
    phase_e      phase;
    logic        doing_rewire;
    logic [47:0] held_src_vaddr;
    logic [47:0] held_dst_vaddr;
    logic [21:0] src_page_base;
    logic [51:0] dst_entry_addr;
  } walk_state_t;

  typedef struct packed {
    kind_e       kind;
    logic [51:0] mem_address;
    logic [63:0] write_data;
    status_e     status;
    logic [51:0] phys_addr;
    logic        last;
  } result_t;

  function automatic logic [51:0] top_entry_addr(logic [51:0] root, logic [47:0] va);
    return {root[51:12], va[47:39], 3'b000};
  endfunction

  function automatic logic [51:0] pdpt_entry_addr(logic [63:0] e, logic [47:0] va);
    return {e[51:12], va[38:30], 3'b000};
  endfunction

  function automatic logic [51:0] phys_of(logic [21:0] base, logic [47:0] va);
    return {base, va[29:0]};
  endfunction

endpackage

// File: hdl/page_walk_1g_rewire.sv
// Page walker for 1 GiB pages over an external memory port. An item with func 0
// translates src_vaddr, func 1 rewires the page of dst_vaddr to the page of
// src_vaddr, and func 2 returns the entry read for the last read request. Each
// accepted item is captured in an input register; once the output queue has room,
// one pass of combinational logic updates the walk state and pushes zero, one or
// two result items into a four-entry output queue. One item can be accepted every
// cycle while in_stall_o is low; in_stall_o rises only while the input register
// holds an item and the output queue has fewer than two free entries. Items that
// arrive out of sequence (func 0 or 1 during a walk, func 2 while idle, func 3
// always) leave no result. cfg_wr_data_i loads table_root (bits 51:12 are the top
// table base); the user must write it only while the walker is idle, which the
// block itself does not enforce.
module page_walk_1g_rewire import pwr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_wr_en_i,
  input  logic [51:0] cfg_wr_data_i,
  // input items
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [47:0] src_vaddr_i,
  input  logic [47:0] dst_vaddr_i,
  input  logic [63:0] read_data_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [51:0] mem_address_o,
  output logic [63:0] write_data_o,
  output logic [1:0]  status_o,
  output logic [51:0] phys_addr_o,
  output logic        last_o
);

  // table root register
  logic [51:0] table_root_q;

  // input register stage
  logic        s1_valid_q, s1_valid_d;
  logic [1:0]  s1_func_q;
  logic [47:0] s1_src_q;
  logic [47:0] s1_dst_q;
  logic [63:0] s1_data_q;
  logic        in_accept;
  logic        s1_adv;

  // walk state
  walk_state_t state_q, state_d;

  // step results
  logic [1:0]  n_res;
  logic [1:0]  push_cnt;
  result_t     res0, res1;

  // output queue
  logic        oq_room;
  logic        oq_not_empty;
  result_t     oq_head;

  assign in_stall_o = s1_valid_q & ~oq_room;
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign s1_adv     = s1_valid_q & oq_room;
  assign s1_valid_d = in_accept | (s1_valid_q & ~s1_adv);
  assign push_cnt   = s1_adv ? n_res : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_root_q <= '0;
    end else if (cfg_wr_en_i) begin
      table_root_q <= cfg_wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // payload of the input register, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_func_q <= func_i;
      s1_src_q  <= src_vaddr_i;
      s1_dst_q  <= dst_vaddr_i;
      s1_data_q <= read_data_i;
    end
  end

  // walk state moves only when the registered item is processed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_IDLE, doing_rewire: 1'b0, held_src_vaddr: '0,
                   held_dst_vaddr: '0, src_page_base: '0, dst_entry_addr: '0};
    end else if (s1_adv) begin
      state_q <= state_d;
    end
  end

  pwr_walk_step u_step (
    .state_i      (state_q),
    .table_root_i (table_root_q),
    .func_i       (s1_func_q),
    .src_vaddr_i  (s1_src_q),
    .dst_vaddr_i  (s1_dst_q),
    .read_data_i  (s1_data_q),
    .state_o      (state_d),
    .n_res_o      (n_res),
    .res0_o       (res0),
    .res1_o       (res1)
  );

  pwr_out_queue u_oq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (push_cnt),
    .wr0_i       (res0),
    .wr1_i       (res1),
    .pop_i       (~out_stall_i),
    .room_o      (oq_room),
    .not_empty_o (oq_not_empty),
    .head_o      (oq_head)
  );

  assign out_valid_o   = oq_not_empty;
  assign kind_o        = oq_head.kind;
  assign mem_address_o = oq_head.mem_address;
  assign write_data_o  = oq_head.write_data;
  assign status_o      = oq_head.status;
  assign phys_addr_o   = oq_head.phys_addr;
  assign last_o        = oq_head.last;

  // a done result always closes the walk
  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && n_res != 2'd0 && res0.kind == KIND_DONE) |=> state_q.phase == PH_IDLE)
    else $error("walk not idle after done result");

  // a data return while idle is dropped
  a_idle_data_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && state_q.phase == PH_IDLE && s1_func_q == FUNC_DATA) |-> n_res == 2'd0)
    else $error("data return while idle produced a result");

  // a pair of results is only the write then re-read of the destination entry
  a_pair_is_write_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && n_res == 2'd2) |-> (res0.kind == KIND_WRITE && !res0.last &&
      res1.kind == KIND_READ && res1.mem_address == res0.mem_address))
    else $error("malformed write and re-read pair");

  // the input register never holds an item across a cycle with queue room
  a_s1_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && oq_room && !in_valid_i) |=> !s1_valid_q)
    else $error("input register did not drain");

endmodule

// File: hdl/pwr_walk_step.sv
module pwr_walk_step import pwr_pkg::*; (
  input  walk_state_t state_i,
  input  logic [51:0] table_root_i,
  input  logic [1:0]  func_i,
  input  logic [47:0] src_vaddr_i,
  input  logic [47:0] dst_vaddr_i,
  input  logic [63:0] read_data_i,
  output walk_state_t state_o,
  output logic [1:0]  n_res_o,
  output result_t     res0_o,
  output result_t     res1_o
);

  logic        present;
  logic        page_ok;
  logic [51:0] spa;
  logic [51:0] dpa;
  result_t     read_req;
  result_t     done_res;

  assign present = read_data_i[PRESENT_BIT];
  assign page_ok = read_data_i[PRESENT_BIT] & read_data_i[PS_BIT];
  assign spa     = phys_of(state_i.src_page_base, state_i.held_src_vaddr);
  assign dpa     = phys_of(read_data_i[51:30], state_i.held_dst_vaddr);

  always_comb begin
    state_o  = state_i;
    n_res_o  = 2'd0;
    read_req = '{kind: KIND_READ, mem_address: '0, write_data: '0, status: ST_MISMATCH,
                 phys_addr: '0, last: 1'b1};
    done_res = '{kind: KIND_DONE, mem_address: '0, write_data: '0, status: ST_FAULT,
                 phys_addr: '0, last: 1'b1};
    res0_o   = read_req;
    res1_o   = read_req;

    case (state_i.phase)
      PH_IDLE: begin
        if (func_i == FUNC_XLATE || func_i == FUNC_REWIRE) begin
          state_o.doing_rewire   = (func_i == FUNC_REWIRE);
          state_o.held_src_vaddr = src_vaddr_i;
          state_o.held_dst_vaddr = (func_i == FUNC_REWIRE) ? dst_vaddr_i : '0;
          res0_o.mem_address     = top_entry_addr(table_root_i, src_vaddr_i);
          state_o.phase          = PH_SRC_TOP;
          n_res_o                = 2'd1;
        end
      end
      PH_SRC_TOP: begin
        if (func_i == FUNC_DATA) begin
          n_res_o = 2'd1;
          if (!present) begin
            res0_o        = done_res;
            state_o.phase = PH_IDLE;
          end else begin
            res0_o.mem_address = pdpt_entry_addr(read_data_i, state_i.held_src_vaddr);
            state_o.phase      = PH_SRC_PDPT;
          end
        end
      end
      PH_SRC_PDPT: begin
        if (func_i == FUNC_DATA) begin
          n_res_o = 2'd1;
          if (!page_ok) begin
            res0_o        = done_res;
            state_o.phase = PH_IDLE;
          end else begin
            state_o.src_page_base = read_data_i[51:30];
            if (!state_i.doing_rewire) begin
              res0_o           = done_res;
              res0_o.status    = ST_SUCCESS;
              res0_o.phys_addr = phys_of(read_data_i[51:30], state_i.held_src_vaddr);
              state_o.phase    = PH_IDLE;
            end else begin
              res0_o.mem_address = top_entry_addr(table_root_i, state_i.held_dst_vaddr);
              state_o.phase      = PH_DST_TOP;
            end
          end
        end
      end
      PH_DST_TOP: begin
        if (func_i == FUNC_DATA) begin
          n_res_o = 2'd1;
          if (!present) begin
            res0_o        = done_res;
            state_o.phase = PH_IDLE;
          end else begin
            state_o.dst_entry_addr = pdpt_entry_addr(read_data_i, state_i.held_dst_vaddr);
            res0_o.mem_address     = pdpt_entry_addr(read_data_i, state_i.held_dst_vaddr);
            state_o.phase          = PH_DST_PDPT;
          end
        end
      end
      PH_DST_PDPT: begin
        if (func_i == FUNC_DATA) begin
          n_res_o            = 2'd2;
          res0_o.kind        = KIND_WRITE;
          res0_o.mem_address = state_i.dst_entry_addr;
          res0_o.write_data  = {read_data_i[63:52], state_i.src_page_base, read_data_i[29:0]};
          res0_o.last        = 1'b0;
          res1_o.mem_address = state_i.dst_entry_addr;
          state_o.phase      = PH_RECHECK;
        end
      end
      PH_RECHECK: begin
        if (func_i == FUNC_DATA) begin
          n_res_o       = 2'd1;
          res0_o        = done_res;
          state_o.phase = PH_IDLE;
          if (page_ok) begin
            if (spa == dpa) begin
              res0_o.status    = ST_SUCCESS;
              res0_o.phys_addr = spa;
            end else begin
              res0_o.status = ST_MISMATCH;
            end
          end
        end
      end
      default: begin
        state_o.phase = PH_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/pwr_out_queue.sv
module pwr_out_queue import pwr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic [1:0] push_cnt_i,
  input  result_t wr0_i,
  input  result_t wr1_i,
  input  logic    pop_i,
  output logic    room_o,
  output logic    not_empty_o,
  output result_t head_o
);

  result_t               mem_q [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]   head_q, head_d;
  logic [OQ_PTR_W-1:0]   tail_q, tail_d;
  logic [OQ_CNT_W-1:0]   cnt_q, cnt_d;
  logic [OQ_PTR_W-1:0]   tail_p1;
  logic                  do_pop;

  // two free slots needed, since one item can leave up to two results
  assign room_o      = (cnt_q <= OQ_CNT_W'(OQ_DEPTH - 2));
  assign not_empty_o = (cnt_q != '0);
  assign head_o      = mem_q[head_q];
  assign do_pop      = pop_i & not_empty_o;
  assign tail_p1     = tail_q + OQ_PTR_W'(1);

  always_comb begin
    head_d = head_q + OQ_PTR_W'(do_pop);
    tail_d = tail_q + OQ_PTR_W'(push_cnt_i);
    cnt_d  = cnt_q + OQ_CNT_W'(push_cnt_i) - OQ_CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[tail_q] <= wr0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[tail_p1] <= wr1_i;
    end
  end

endmodule
